>>> hw/rtl/bale_pkg.sv
`timescale 1ns / 1ps

package bale_pkg;

   // list geometry
   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int WORD_W  = 32;

   // fixed field widths
   localparam int MODE_W  = 2;
   localparam int POS_W   = 5;
   localparam int STAT_W  = 3;
   localparam int FOUND_W = 4;
   localparam int COUNT_W = 5;

   // pointer wide enough for both a position and a count
   localparam int PTR_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

   // packed stream widths
   localparam int REQ_DATA_W = ((WORD_W + POS_W + 7) / 8) * 8;
   localparam int RSP_FLD_W  = STAT_W + FOUND_W + COUNT_W;
   localparam int RSP_DATA_W = ((RSP_FLD_W + 7) / 8) * 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_LOCATE = 2'd2,
      MODE_SORTED = 2'd3
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_EMPTY    = 3'd2,
      STAT_BADPOS   = 3'd3,
      STAT_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_READ,
      S_EVAL,
      S_PUT,
      S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;  // capture the accepted request
      logic init;      // precheck result and start pointer
      logic rd;        // read the next entry
      logic step;      // advance the pointer, moving an entry except in locate
      logic hit;       // locate matched at the pointer
      logic put;       // write the request value at the pointer
      logic load_rsp;  // commit count and load the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic chk_fail;   // request rejected up front
      logic loop_more;  // another entry to visit
      logic eval_go;    // keep walking after this entry
      logic hit;        // locate found the value
      logic needs_put;  // value gets written at the end
   } sts_type;

endpackage

>>> hw/rtl/bale_ctrl.sv
`timescale 1ns / 1ps

module bale_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  bale_pkg::sts_type sts,
   output bale_pkg::cmd_type cmd
);
   import bale_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // state and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.init = 1'b1;
            state_in = sts.chk_fail ? S_DONE : S_READ;
         end
         S_READ: begin
            if (sts.loop_more) begin
               cmd.rd   = 1'b1;
               state_in = S_EVAL;
            end else if (sts.needs_put) begin
               state_in = S_PUT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_EVAL: begin
            if (sts.hit) begin
               cmd.hit  = 1'b1;
               state_in = S_DONE;
            end else if (sts.eval_go) begin
               cmd.step = 1'b1;
               state_in = S_READ;
            end else begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            cmd.put  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            // wait for room in the result register
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid: set on load, cleared on transfer
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> hw/rtl/bale_dp.sv
`timescale 1ns / 1ps

module bale_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [bale_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [bale_pkg::MODE_W-1:0]     req_tuser,
   output logic [bale_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  bale_pkg::cmd_type               cmd,
   output bale_pkg::sts_type               sts
);
   import bale_pkg::*;

   // list storage, one write and one registered read per cycle
   logic signed [WORD_W-1:0] mem [DEPTH];
   logic signed [WORD_W-1:0] rd_data_ff;

   // request and walk registers
   mode_type                 mode_ff;
   logic signed [WORD_W-1:0] value_ff;
   logic [POS_W-1:0]         pos_ff;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [PTR_W-1:0]         ptr_ff, ptr_in;
   status_type               status_ff, status_in;
   logic [FOUND_W-1:0]       found_ff, found_in;

   // result register
   status_type               rsp_status_ff;
   logic [FOUND_W-1:0]       rsp_found_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;

   logic [PTR_W-1:0]         cnt_x;
   logic [PTR_W-1:0]         pos_x;
   logic [PTR_W-1:0]         ptr_dec;
   logic [PTR_W-1:0]         ptr_inc;
   logic [PTR_W-1:0]         rd_ptr;
   status_type               chk_status;
   logic                     match;
   logic                     le;
   logic                     wr_en;
   logic signed [WORD_W-1:0] wr_data;

   assign cnt_x   = PTR_W'(cnt_ff);
   assign pos_x   = PTR_W'(pos_ff);
   assign ptr_dec = ptr_ff - PTR_W'(1);
   assign ptr_inc = ptr_ff + PTR_W'(1);
   assign match   = (rd_data_ff == value_ff);
   assign le      = (value_ff <= rd_data_ff);

   // up-front checks
   always_comb begin
      chk_status = STAT_OK;
      case (mode_ff)
         MODE_INSERT: begin
            if (cnt_x >= PTR_W'(DEPTH))  chk_status = STAT_FULL;
            else if (pos_x > cnt_x)      chk_status = STAT_BADPOS;
         end
         MODE_DELETE: begin
            if (cnt_x == '0)             chk_status = STAT_EMPTY;
            else if (pos_x >= cnt_x)     chk_status = STAT_BADPOS;
         end
         MODE_LOCATE: begin
            chk_status = STAT_NOTFOUND;
         end
         MODE_SORTED: begin
            if (cnt_x >= PTR_W'(DEPTH))  chk_status = STAT_FULL;
         end
         default: begin
            chk_status = STAT_OK;
         end
      endcase
   end

   // per-mode walk control
   always_comb begin
      sts           = '0;
      sts.chk_fail  = (mode_ff != MODE_LOCATE) && (chk_status != STAT_OK);
      sts.needs_put = (mode_ff == MODE_INSERT) || (mode_ff == MODE_SORTED);
      rd_ptr        = ptr_dec;
      case (mode_ff)
         MODE_INSERT: begin
            sts.loop_more = (ptr_ff > pos_x);
            sts.eval_go   = 1'b1;
         end
         MODE_DELETE: begin
            rd_ptr        = ptr_inc;
            sts.loop_more = (ptr_inc < cnt_x);
            sts.eval_go   = 1'b1;
         end
         MODE_LOCATE: begin
            rd_ptr        = ptr_ff;
            sts.loop_more = (ptr_ff < cnt_x);
            sts.eval_go   = !match;
            sts.hit       = match;
         end
         MODE_SORTED: begin
            sts.loop_more = (ptr_ff != '0);
            sts.eval_go   = le;
         end
         default: begin
            sts.loop_more = 1'b0;
         end
      endcase
   end

   // memory write: shifted entry or the new value
   assign wr_en   = (cmd.step && (mode_ff != MODE_LOCATE)) || cmd.put;
   assign wr_data = cmd.put ? value_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[ptr_ff[IDX_W-1:0]] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[rd_ptr[IDX_W-1:0]];
      end
   end

   // pointer, status and found index
   always_comb begin
      ptr_in    = ptr_ff;
      status_in = status_ff;
      found_in  = found_ff;
      if (cmd.init) begin
         status_in = chk_status;
         found_in  = '0;
         case (mode_ff)
            MODE_INSERT: ptr_in = cnt_x;
            MODE_DELETE: ptr_in = pos_x;
            MODE_LOCATE: ptr_in = '0;
            MODE_SORTED: ptr_in = cnt_x;
            default:     ptr_in = '0;
         endcase
      end else if (cmd.hit) begin
         status_in = STAT_OK;
         found_in  = FOUND_W'(ptr_ff);
      end else if (cmd.step) begin
         if ((mode_ff == MODE_INSERT) || (mode_ff == MODE_SORTED)) begin
            ptr_in = ptr_dec;
         end else begin
            ptr_in = ptr_inc;
         end
      end
   end

   // count commits when the result is loaded
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.load_rsp && (status_ff == STAT_OK)) begin
         if ((mode_ff == MODE_INSERT) || (mode_ff == MODE_SORTED)) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end else if (mode_ff == MODE_DELETE) begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff  <= mode_type'(req_tuser);
         value_ff <= req_tdata[WORD_W-1:0];
         pos_ff   <= req_tdata[WORD_W+POS_W-1:WORD_W];
      end
      ptr_ff    <= ptr_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_ff;
         rsp_count_ff  <= COUNT_W'(cnt_in);
      end
   end

   assign rsp_tdata = {{(RSP_DATA_W - RSP_FLD_W){1'b0}},
                       rsp_count_ff, rsp_found_ff, rsp_status_ff};

endmodule

>>> hw/rtl/bounded_array_list_engine_unit.sv
`timescale 1ns / 1ps
// Bounded list engine: keeps up to 16 signed words plus a count.
// Request channel (req_): tuser carries the operation (insert at position,
// delete at position, locate value, sorted insert); tdata carries the
// value and the position. Each request transfer yields exactly one result
// transfer on rsp_ with status, found index and the entry count after it.
// Requests are taken one at a time: tready is high only while the engine is
// idle, so the next request can transfer in the cycle after a result loads.
// Each visited entry takes a registered read of the list memory, then a
// compare or a write back. Insert and delete move up to 15 entries, locate
// scans up to 16 on a hit or a miss, and sorted insert stops at the first
// smaller entry or moves all entries. Rejected requests (full, empty, bad
// position) go straight to the result without a walk.
// The result sits in an output register; a new request is taken while it
// waits, and if the receiver stalls, the next result waits in the engine
// until the register frees up. Reset empties the list (count zero) and
// drops any pending result; the list memory itself is not cleared.

module bounded_array_list_engine_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // req_tdata, low to high: value[31:0], position[36:32], zero pad
   input  logic [bale_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: mode[1:0]
   input  logic [bale_pkg::MODE_W-1:0]     req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_tdata, low to high: status[2:0], found_index[6:3],
   // entry_count[11:7], zero pad
   output logic [bale_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bale_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bale_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bale_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

>>> hw/rtl/bale_chk.sv
`timescale 1ns / 1ps

module bale_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bale_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bale_pkg::*;

   // one request at a time: tready drops right after a transfer
   a_req_single: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // a stalled result keeps its valid and its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   // reset leaves no result pending
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // count never exceeds the list depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[STAT_W+FOUND_W+COUNT_W-1:STAT_W+FOUND_W]
                     <= COUNT_W'(DEPTH))
      else $error("entry count beyond depth");

   // found index is zero unless the status is ok
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[STAT_W-1:0] != STAT_OK)
         |-> rsp_tdata[STAT_W+FOUND_W-1:STAT_W] == '0)
      else $error("found index set on a failed request");

endmodule

bind bounded_array_list_engine_unit bale_chk u_bale_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/tb_bounded_array_list_engine_unit.sv
`timescale 1ns / 1ps

module tb_bounded_array_list_engine_unit;
   import bale_pkg::*;

   // one expected result transfer
   typedef struct {
      status_type         status;
      logic [FOUND_W-1:0] found;
      logic [COUNT_W-1:0] count;
   } outcome_type;

   // shadow copy of the list plus the queue of results still owed
   class list_tracker;
      logic signed [WORD_W-1:0] slots [DEPTH];
      int       fill;
      int       errors;
      outcome_type expected_outcomes [$];

      function new();
         fill = 0;
         errors = 0;
         foreach (slots[k]) slots[k] = '0;
      endfunction

      function int pending();
         return expected_outcomes.size();
      endfunction

      // apply one accepted request to the shadow list
      function void note_request(mode_type mode, logic signed [WORD_W-1:0] value,
                                 logic [POS_W-1:0] pos);
         outcome_type o;
         int at;
         int i;
         at = int'(pos);
         o.status = STAT_OK;
         o.found = '0;
         case (mode)
            MODE_INSERT: begin
               if (fill >= DEPTH) o.status = STAT_FULL;
               else if (at > fill) o.status = STAT_BADPOS;
               else begin
                  for (i = fill; i > at; i--) slots[i] = slots[i-1];
                  slots[at] = value;
                  fill++;
               end
            end
            MODE_DELETE: begin
               if (fill == 0) o.status = STAT_EMPTY;
               else if (at >= fill) o.status = STAT_BADPOS;
               else begin
                  for (i = at; i + 1 < fill; i++) slots[i] = slots[i+1];
                  fill--;
               end
            end
            MODE_LOCATE: begin
               o.status = STAT_NOTFOUND;
               for (i = 0; i < fill; i++) begin
                  if (o.status == STAT_NOTFOUND && slots[i] == value) begin
                     o.status = STAT_OK;
                     o.found = FOUND_W'(i);
                  end
               end
            end
            default: begin
               // sorted insert: walk down past entries >= value
               if (fill >= DEPTH) o.status = STAT_FULL;
               else begin
                  i = fill;
                  while (i > 0 && value <= slots[i-1]) begin
                     slots[i] = slots[i-1];
                     i--;
                  end
                  slots[i] = value;
                  fill++;
               end
            end
         endcase
         o.count = COUNT_W'(fill);
         expected_outcomes.push_back(o);
      endfunction

      // compare one result transfer with the oldest expectation
      function void check_response(logic [RSP_DATA_W-1:0] tdata);
         outcome_type want;
         logic [STAT_W-1:0]  got_status;
         logic [FOUND_W-1:0] got_found;
         logic [COUNT_W-1:0] got_count;
         got_status = tdata[STAT_W-1:0];
         got_found  = tdata[STAT_W +: FOUND_W];
         got_count  = tdata[STAT_W+FOUND_W +: COUNT_W];
         if (expected_outcomes.size() == 0) begin
            $display("%0t: result with nothing expected: actual tdata %h", $time, tdata);
            errors++;
            return;
         end
         want = expected_outcomes.pop_front();
         if (got_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got_status);
            errors++;
         end
         if (got_found !== want.found) begin
            $display("%0t: found_index expected %0d actual %0d", $time, want.found,
                     got_found);
            errors++;
         end
         if (got_count !== want.count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                     got_count);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   list_tracker board = new();

   int burst_left = 4;
   int grow = 1;
   int keep_sorted = 0;
   int stall_style = 0;
   int stall_timer = 0;
   int stall_hold = 0;

   bounded_array_list_engine_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: check each result transfer, stall in changing styles
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
         if (stall_timer == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_timer = $urandom_range(50, 200);
         end else begin
            stall_timer--;
         end
         case (stall_style)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: begin
               // long stalls between runs of readiness
               if (stall_hold > 0) begin
                  stall_hold--;
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
                  if ($urandom_range(0, 5) == 0) stall_hold = $urandom_range(1, 12);
               end
            end
         endcase
      end
   end

   // hold off new requests until every result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // one request transfer, then maybe a gap between bursts
   task automatic send_request(mode_type mode, logic signed [WORD_W-1:0] value,
                               logic [POS_W-1:0] pos);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {{(REQ_DATA_W-WORD_W-POS_W){1'b0}}, pos, value};
      do @(posedge clock); while (!req_tready);
      board.note_request(mode, value, pos);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 20);
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // data word: often one already in the list, small ones for duplicates
   function automatic logic signed [WORD_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40 && board.fill > 0) return board.slots[$urandom_range(0, board.fill - 1)];
      if (r < 70) return $signed(WORD_W'($urandom_range(0, 16))) - 8;
      if (r < 80) begin
         case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return -1;
            default: return 0;
         endcase
      end
      return $urandom;
   endfunction

   // random request, steered so the list swings between empty and full
   task automatic send_random();
      int r;
      mode_type mode;
      logic [POS_W-1:0] pos;
      if (board.fill == DEPTH) grow = 0;
      if (board.fill == 0) grow = 1;
      if ($urandom_range(0, 99) < 3) grow = 1 - grow;
      r = $urandom_range(0, 99);
      if (grow) begin
         if (r < 35) mode = MODE_INSERT;
         else if (r < 65) mode = MODE_SORTED;
         else if (r < 85) mode = MODE_LOCATE;
         else mode = MODE_DELETE;
      end else begin
         if (r < 50) mode = MODE_DELETE;
         else if (r < 70) mode = MODE_LOCATE;
         else if (r < 85) mode = MODE_INSERT;
         else mode = MODE_SORTED;
      end
      // in sorted stretches plain inserts become sorted inserts
      if (keep_sorted && mode == MODE_INSERT) mode = MODE_SORTED;
      if ($urandom_range(0, 99) < 80) begin
         if (mode == MODE_DELETE && board.fill > 0) begin
            pos = POS_W'($urandom_range(0, board.fill - 1));
         end else begin
            pos = POS_W'($urandom_range(0, board.fill));
         end
      end else begin
         pos = POS_W'($urandom_range(0, 16));
      end
      send_request(mode, pick_value(), pos);
   endtask

   initial begin
      int n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty-list cases
      send_request(MODE_DELETE, 0, 0);
      send_request(MODE_LOCATE, 0, 0);
      send_request(MODE_INSERT, 5, 1);
      // extremes, insert at head and at the count
      send_request(MODE_INSERT, 32'sh7FFF_FFFF, 0);
      send_request(MODE_INSERT, 32'sh8000_0000, 0);
      send_request(MODE_INSERT, -1, 2);
      send_request(MODE_LOCATE, 32'sh8000_0000, 5);
      send_request(MODE_LOCATE, 12345, 0);
      send_request(MODE_DELETE, 7, 3);
      send_request(MODE_DELETE, 7, 1);
      // sorted insert into an unsorted list, with duplicates
      send_request(MODE_INSERT, 100, 0);
      send_request(MODE_SORTED, 0, 9);
      send_request(MODE_SORTED, -1, 0);
      send_request(MODE_SORTED, 32'sh8000_0000, 0);
      wait_drained();
      // fill up, then the full-list cases
      while (board.fill < DEPTH - 1) begin
         send_request(MODE_INSERT, board.fill * 1000, POS_W'(board.fill));
      end
      send_request(MODE_INSERT, 32'sh1357_2468, DEPTH - 1);
      send_request(MODE_INSERT, 1, 16);
      send_request(MODE_SORTED, 1, 0);
      send_request(MODE_DELETE, 1, 16);
      send_request(MODE_LOCATE, 32'sh1357_2468, 0);
      send_request(MODE_DELETE, 0, DEPTH - 1);
      send_request(MODE_DELETE, 0, 0);

      for (n = 0; n < 750; n++) begin
         if (n % 100 == 0) keep_sorted = (n / 100) % 2;
         if (n == 375) wait_drained();
         send_random();
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("bounded_array_list_engine_unit: match");
      end else begin
         $display("bounded_array_list_engine_unit: mismatch");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("bounded_array_list_engine_unit: mismatch");
      $finish;
   end

endmodule
